// File: sv/cnp_pkg.sv
package cnp_pkg;

  // Fixed header length of a newc entry, in bytes.
  localparam int HdrBytes = 110;

  // Result queue between the parser and the result port.
  localparam int QueueDepth = 4;
  localparam int QueueAddrW = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Configuration register indexes.
  localparam int CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] CFG_ARCHIVE_LENGTH = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_EMIT_DATA      = 2'd1;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_NAME    = 3'd1,
    PH_NAMEPAD = 3'd2,
    PH_DATA    = 3'd3,
    PH_DATAPAD = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NAME       = 3'd0,
    KIND_DATA       = 3'd1,
    KIND_TRAILER    = 3'd2,
    KIND_LENGTH_END = 3'd3,
    KIND_BAD_MAGIC  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CLASS_NORMAL  = 2'd0,
    CLASS_DOT     = 2'd1,
    CLASS_TRAILER = 2'd2
  } entry_class_t;

  // One result request.
  typedef struct packed {
    kind_t        kind;
    logic [7:0]   byte_value;
    logic         last_of_name;
    entry_class_t entry_class;
    logic         is_directory;
    logic [31:0]  file_size;
    logic         last_of_data;
  } res_t;

  // Configuration write request.
  typedef struct packed {
    logic                 en;
    logic [CfgIndexW-1:0] index;
    logic [31:0]          data;
  } cfg_wr_t;

  // Parser status.
  typedef struct packed {
    logic done;
  } front_stat_t;

  // Result queue status.
  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QueueCntW-1:0] count;
  } queue_stat_t;

endpackage

// File: sv/cpio_newc_archive_stream_parser.sv
// Streaming parser for cpio newc archives. Archive bytes are pushed in order
// from offset zero, at most one per clock cycle; each byte is decoded
// in the cycle it is taken, and the result it causes (a name byte, a data byte
// or an end report) goes into a four-entry result queue. in_full rises only
// when that queue holds four results that have not been popped, so the
// sustained rate is one byte per cycle as long as results are drained. After
// the trailer, a bad magic or a length end, further bytes are taken and
// dropped until reset. Configuration writes are always ready and are meant to
// be issued while the parser is idle.
module cpio_newc_archive_stream_parser
  import cnp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [7:0]           in_archive_byte,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [2:0]           out_kind,
  output logic [7:0]           out_byte_value,
  output logic                 out_last_of_name,
  output logic [1:0]           out_entry_class,
  output logic                 out_is_directory,
  output logic [31:0]          out_file_size,
  output logic                 out_last_of_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic        in_take;
  logic        res_wr;
  res_t        res;
  res_t        head;
  cfg_wr_t     cfg_wr;
  front_stat_t f_stat;
  queue_stat_t q_stat;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid & cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign in_full = q_stat.full;
  assign in_take = in_push & ~q_stat.full;

  // Byte classification and entry tracking.
  cnp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_byte (in_archive_byte),
    .cfg_wr  (cfg_wr),
    .res_wr  (res_wr),
    .res     (res),
    .stat    (f_stat)
  );

  // Result queue toward the consumer.
  cnp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res),
    .rd_en   (out_pop),
    .rd_data (head),
    .stat    (q_stat)
  );

  assign out_empty        = q_stat.empty;
  assign out_kind         = head.kind;
  assign out_byte_value   = head.byte_value;
  assign out_last_of_name = head.last_of_name;
  assign out_entry_class  = head.entry_class;
  assign out_is_directory = head.is_directory;
  assign out_file_size    = head.file_size;
  assign out_last_of_data = head.last_of_data;

  // A result request is never raised while the queue is full.
  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> !q_stat.full)
    else $error("result request raised while queue full");

  // Once parsing has ended, no further result is produced.
  a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    f_stat.done |-> !res_wr)
    else $error("result produced after end of parsing");

  // A pop with no concurrent write lowers the fill count by one.
  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !q_stat.empty && !res_wr) |=>
      (q_stat.count == QueueCntW'($past(q_stat.count) - 1'b1)))
    else $error("queue count did not drop on pop");

endmodule

// File: sv/cnp_front.sv
module cnp_front
  import cnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_take,
  input  logic [7:0]  in_byte,
  input  cfg_wr_t     cfg_wr,
  output logic        res_wr,
  output res_t        res,
  output front_stat_t stat
);

  // Value of one ASCII hex digit; anything else counts as all ones.
  function automatic logic [31:0] hex_val(input logic [7:0] c);
    logic [31:0] v;
    v = 32'hFFFF_FFFF;
    if (c >= 8'h30 && c <= 8'h39) v = {24'd0, c - 8'h30};
    else if (c >= 8'h41 && c <= 8'h46) v = {24'd0, c - 8'h37};
    else if (c >= 8'h61 && c <= 8'h66) v = {24'd0, c - 8'h57};
    return v;
  endfunction

  function automatic logic [7:0] magic_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0, 3'd2, 3'd4: c = 8'h30;
      3'd1, 3'd3:       c = 8'h37;
      3'd5:             c = 8'h31;
      default:          c = 8'h00;
    endcase
    return c;
  endfunction

  // "TRAILER!!!" followed by its NUL.
  function automatic logic [7:0] trailer_char(input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0:             c = 8'h54;
      4'd1:             c = 8'h52;
      4'd2:             c = 8'h41;
      4'd3:             c = 8'h49;
      4'd4:             c = 8'h4C;
      4'd5:             c = 8'h45;
      4'd6:             c = 8'h52;
      4'd7, 4'd8, 4'd9: c = 8'h21;
      default:          c = 8'h00;
    endcase
    return c;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [6:0]  hpos_r, hpos_nxt;
  logic        mgood_r, mgood_nxt;
  logic [31:0] mode_r, mode_nxt;
  logic [31:0] nlen_r, nlen_nxt;
  logic [31:0] dlen_r, dlen_nxt;
  logic [31:0] left_r, left_nxt;
  logic        tmatch_r, tmatch_nxt;
  logic        dmatch_r, dmatch_nxt;
  logic [3:0]  npos_r, npos_nxt;
  logic [31:0] arch_len_r;
  logic        emit_r;

  logic [1:0]  pad;
  logic [31:0] acc_sum;
  logic        mg, tm, dm, trl, show;
  logic [3:0]  np;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_len_r <= 32'hFFFF_FFFF;
      emit_r     <= 1'b1;
    end else if (cfg_wr.en) begin
      case (cfg_wr.index)
        CFG_ARCHIVE_LENGTH: arch_len_r <= cfg_wr.data;
        CFG_EMIT_DATA:      emit_r     <= cfg_wr.data[0];
        default:            ;
      endcase
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      off_r    <= '0;
      acc_r    <= '0;
      hpos_r   <= '0;
      mgood_r  <= 1'b1;
      mode_r   <= '0;
      nlen_r   <= '0;
      dlen_r   <= '0;
      left_r   <= '0;
      tmatch_r <= 1'b1;
      dmatch_r <= 1'b1;
      npos_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      off_r    <= off_nxt;
      acc_r    <= acc_nxt;
      hpos_r   <= hpos_nxt;
      mgood_r  <= mgood_nxt;
      mode_r   <= mode_nxt;
      nlen_r   <= nlen_nxt;
      dlen_r   <= dlen_nxt;
      left_r   <= left_nxt;
      tmatch_r <= tmatch_nxt;
      dmatch_r <= dmatch_nxt;
      npos_r   <= npos_nxt;
    end
  end

  // Classify one byte and build its result request.
  always_comb begin
    phase_nxt  = phase_r;
    off_nxt    = off_r;
    acc_nxt    = acc_r;
    hpos_nxt   = hpos_r;
    mgood_nxt  = mgood_r;
    mode_nxt   = mode_r;
    nlen_nxt   = nlen_r;
    dlen_nxt   = dlen_r;
    left_nxt   = left_r;
    tmatch_nxt = tmatch_r;
    dmatch_nxt = dmatch_r;
    npos_nxt   = npos_r;

    res_wr           = 1'b0;
    res.kind         = KIND_NAME;
    res.byte_value   = 8'd0;
    res.last_of_name = 1'b0;
    res.entry_class  = CLASS_NORMAL;
    res.is_directory = 1'b0;
    res.file_size    = dlen_r;
    res.last_of_data = 1'b0;

    // Padding needed after the byte now taken, to the next multiple of four.
    pad     = 2'(2'd0 - 2'(off_r[1:0] + 2'd1));
    acc_sum = (acc_r << 4) + hex_val(in_byte);
    mg      = mgood_r & ((hpos_r >= 7'd6) | (in_byte == magic_char(hpos_r[2:0])));
    tm      = tmatch_r & ((npos_r >= 4'd11) | (in_byte == trailer_char(npos_r)));
    dm      = dmatch_r & ((npos_r >= 4'd2)
              | (in_byte == (npos_r[0] ? 8'h00 : 8'h2E)));
    np      = (npos_r == 4'd15) ? npos_r : 4'(npos_r + 4'd1);
    trl     = tm & (np >= 4'd11);
    show    = emit_r & ~(dmatch_r & (npos_r >= 4'd2));

    if (in_take && phase_r != PH_DONE) begin
      off_nxt = off_r + 32'd1;
      case (phase_r)
        PH_HEADER: begin
          if (hpos_r == 7'd0 && off_r >= arch_len_r) begin
            res_wr    = 1'b1;
            res.kind  = KIND_LENGTH_END;
            phase_nxt = PH_DONE;
          end else begin
            mgood_nxt = mg;
            acc_nxt   = acc_sum;
            if (hpos_r == 7'd5 && !mg) begin
              res_wr    = 1'b1;
              res.kind  = KIND_BAD_MAGIC;
              phase_nxt = PH_DONE;
            end else begin
              if (hpos_r == 7'd21)  mode_nxt = acc_sum;
              if (hpos_r == 7'd61)  dlen_nxt = acc_sum;
              if (hpos_r == 7'd101) nlen_nxt = acc_sum;
              if (hpos_r == 7'(HdrBytes - 1)) begin
                hpos_nxt = '0;
                if (nlen_r == 32'd0) begin
                  // An empty name is reported as bad magic.
                  res_wr    = 1'b1;
                  res.kind  = KIND_BAD_MAGIC;
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt  = PH_NAME;
                  left_nxt   = nlen_r;
                  npos_nxt   = '0;
                  tmatch_nxt = 1'b1;
                  dmatch_nxt = 1'b1;
                end
              end else begin
                hpos_nxt = 7'(hpos_r + 7'd1);
              end
            end
          end
        end

        PH_NAME: begin
          tmatch_nxt     = tm;
          dmatch_nxt     = dm;
          npos_nxt       = np;
          left_nxt       = left_r - 32'd1;
          res_wr         = 1'b1;
          res.byte_value = in_byte;
          if (left_r == 32'd1) begin
            res.last_of_name = 1'b1;
            res.is_directory = (mode_r[15:12] == 4'b0100);
            if (trl) res.entry_class = CLASS_TRAILER;
            else if (dm && np >= 4'd2) res.entry_class = CLASS_DOT;
            if (trl) begin
              res.kind  = KIND_TRAILER;
              phase_nxt = PH_DONE;
            end else if (pad != 2'd0) begin
              phase_nxt = PH_NAMEPAD;
              left_nxt  = {30'd0, pad};
            end else if (dlen_r != 32'd0) begin
              phase_nxt = PH_DATA;
              left_nxt  = dlen_r;
            end else begin
              phase_nxt = PH_HEADER;
              hpos_nxt  = '0;
              mgood_nxt = 1'b1;
            end
          end
        end

        PH_NAMEPAD: begin
          left_nxt = left_r - 32'd1;
          if (left_r == 32'd1) begin
            if (dlen_r != 32'd0) begin
              phase_nxt = PH_DATA;
              left_nxt  = dlen_r;
            end else if (pad != 2'd0) begin
              phase_nxt = PH_DATAPAD;
              left_nxt  = {30'd0, pad};
            end else begin
              phase_nxt = PH_HEADER;
              hpos_nxt  = '0;
              mgood_nxt = 1'b1;
            end
          end
        end

        PH_DATA: begin
          left_nxt = left_r - 32'd1;
          if (show) begin
            res_wr           = 1'b1;
            res.kind         = KIND_DATA;
            res.byte_value   = in_byte;
            res.last_of_data = (left_r == 32'd1);
          end
          if (left_r == 32'd1) begin
            if (pad != 2'd0) begin
              phase_nxt = PH_DATAPAD;
              left_nxt  = {30'd0, pad};
            end else begin
              phase_nxt = PH_HEADER;
              hpos_nxt  = '0;
              mgood_nxt = 1'b1;
            end
          end
        end

        PH_DATAPAD: begin
          left_nxt = left_r - 32'd1;
          if (left_r == 32'd1) begin
            phase_nxt = PH_HEADER;
            hpos_nxt  = '0;
            mgood_nxt = 1'b1;
          end
        end

        default: phase_nxt = PH_DONE;
      endcase
    end
  end

  assign stat.done = (phase_r == PH_DONE);

endmodule

// File: sv/cnp_queue.sv
module cnp_queue
  import cnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  res_t        wr_data,
  input  logic        rd_en,
  output res_t        rd_data,
  output queue_stat_t stat
);

  res_t                  mem_r [QueueDepth];
  logic [QueueAddrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QueueAddrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QueueCntW-1:0]  cnt_r, cnt_nxt;
  logic                  do_wr, do_rd;

  assign stat.full  = (cnt_r == QueueCntW'(QueueDepth));
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;

  assign do_wr = wr_en & ~stat.full;
  assign do_rd = rd_en & ~stat.empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_wr ? QueueAddrW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? QueueAddrW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = QueueCntW'(cnt_r + 1'b1);
    else if (do_rd && !do_wr) cnt_nxt = QueueCntW'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

  assign rd_data = mem_r[rd_ptr_r];

endmodule

// File: bench/cpio_newc_archive_stream_parser_tb.sv
module cpio_newc_archive_stream_parser_tb;
  import cnp_pkg::*;

  localparam int CycleLimit = 300000;

  localparam logic [47:0] MagicText   = "070701";
  localparam logic [79:0] TrailerText = "TRAILER!!!";

  // Ways the archive is brought to its end.
  localparam int END_TRAILER   = 0;
  localparam int END_BAD_MAGIC = 1;
  localparam int END_NO_NAME   = 2;
  localparam int END_LENGTH    = 3;

  // Bytes that are not hex digits, with the neighbors of each digit range.
  logic [7:0] non_hex [10] = '{8'h00, 8'h2F, 8'h3A, 8'h40, 8'h47,
                               8'h60, 8'h67, 8'h7A, 8'h80, 8'hFF};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic [7:0]        in_archive_byte = 8'd0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [2:0]        out_kind;
  logic [7:0]        out_byte_value;
  logic              out_last_of_name;
  logic [1:0]        out_entry_class;
  logic              out_is_directory;
  logic [31:0]       out_file_size;
  logic              out_last_of_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [31:0]       cfg_data = 32'd0;

  cpio_newc_archive_stream_parser u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_archive_byte  (in_archive_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_kind         (out_kind),
    .out_byte_value   (out_byte_value),
    .out_last_of_name (out_last_of_name),
    .out_entry_class  (out_entry_class),
    .out_is_directory (out_is_directory),
    .out_file_size    (out_file_size),
    .out_last_of_data (out_last_of_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  // Archive bytes waiting to be sent, and parser records waiting to come out.
  logic [7:0]  archive_bytes[$];
  res_t        parsed_records[$];
  logic [7:0]  name_buf[$];
  int unsigned stream_len = 0;
  int unsigned bytes_taken = 0;
  int unsigned records_seen = 0;
  int unsigned cycle_count = 0;
  int          mismatch_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          bad_digit_pct = 0;
  bit          byte_taken = 1'b0;
  bit          hold_for_results = 1'b0;
  bit          forced_pause_done = 1'b0;

  // Parser model state and its copy of the registers.
  phase_t      arc_phase = PH_HEADER;
  logic [31:0] arc_offset = 32'd0;
  logic [31:0] hex_acc = 32'd0;
  logic [6:0]  hdr_pos = 7'd0;
  logic        magic_ok = 1'b1;
  logic [31:0] mode_val = 32'd0;
  logic [31:0] name_len = 32'd0;
  logic [31:0] file_len = 32'd0;
  logic [31:0] run_left = 32'd0;
  logic        trl_ok = 1'b1;
  logic        dot_ok = 1'b1;
  logic [3:0]  name_pos = 4'd0;
  logic [31:0] length_limit = 32'hFFFF_FFFF;
  logic        data_on = 1'b1;

  function automatic logic [31:0] hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {24'd0, 8'(c - 8'h30)};
    if (c >= "A" && c <= "F") return {24'd0, 8'(c - 8'h41)} + 32'd10;
    if (c >= "a" && c <= "f") return {24'd0, 8'(c - 8'h61)} + 32'd10;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic void enter_header();
    arc_phase = PH_HEADER;
    hdr_pos   = 7'd0;
    magic_ok  = 1'b1;
  endfunction

  // Skip data padding up to the next 4-byte boundary, if any.
  function automatic void enter_data_pad(input logic [31:0] nxt);
    logic [31:0] pad;
    pad = (32'd0 - nxt) & 32'd3;
    if (pad != 0) begin
      arc_phase = PH_DATAPAD;
      run_left  = pad;
    end else begin
      enter_header();
    end
  endfunction

  function automatic void enter_data(input logic [31:0] nxt);
    if (file_len != 0) begin
      arc_phase = PH_DATA;
      run_left  = file_len;
    end else begin
      enter_data_pad(nxt);
    end
  endfunction

  // Advances the parser model by one archive byte; returns 1 when a record is due.
  function automatic bit parse_archive_byte(input logic [7:0] b, output res_t rec);
    logic [31:0] off;
    logic [31:0] nxt;
    logic [31:0] pad;
    logic [7:0]  tchar;
    logic [7:0]  dchar;
    bit          trl;
    bit          show;
    rec = '0;
    rec.file_size = file_len;
    if (arc_phase == PH_DONE) return 1'b0;
    off = arc_offset;
    arc_offset = off + 32'd1;
    nxt = arc_offset;
    case (arc_phase)
      PH_HEADER: begin
        if (hdr_pos == 0 && off >= length_limit) begin
          rec.kind  = KIND_LENGTH_END;
          arc_phase = PH_DONE;
          return 1'b1;
        end
        if (hdr_pos < 6 && b != MagicText[47 - 8*hdr_pos -: 8]) magic_ok = 1'b0;
        hex_acc = (hex_acc << 4) + hex_value(b);
        if (hdr_pos == 5 && !magic_ok) begin
          rec.kind  = KIND_BAD_MAGIC;
          arc_phase = PH_DONE;
          return 1'b1;
        end
        if (hdr_pos == 21) mode_val = hex_acc;
        if (hdr_pos == 61) begin
          file_len = hex_acc;
          rec.file_size = file_len;
        end
        if (hdr_pos == 101) name_len = hex_acc;
        if (hdr_pos + 1 >= HdrBytes) begin
          hdr_pos = 7'd0;
          if (name_len == 0) begin
            rec.kind  = KIND_BAD_MAGIC;
            arc_phase = PH_DONE;
            return 1'b1;
          end
          arc_phase = PH_NAME;
          run_left  = name_len;
          name_pos  = 4'd0;
          trl_ok    = 1'b1;
          dot_ok    = 1'b1;
          return 1'b0;
        end
        hdr_pos = hdr_pos + 7'd1;
        return 1'b0;
      end
      PH_NAME: begin
        tchar = (name_pos < 10) ? TrailerText[79 - 8*name_pos -: 8] : 8'h00;
        dchar = (name_pos == 0) ? "." : 8'h00;
        if (name_pos < 11 && b != tchar) trl_ok = 1'b0;
        if (name_pos < 2 && b != dchar) dot_ok = 1'b0;
        if (name_pos < 15) name_pos = name_pos + 4'd1;
        run_left = run_left - 32'd1;
        rec.kind       = KIND_NAME;
        rec.byte_value = b;
        if (run_left == 0) begin
          trl = trl_ok && name_pos >= 11;
          rec.last_of_name = 1'b1;
          if (trl) rec.entry_class = CLASS_TRAILER;
          else if (dot_ok && name_pos >= 2) rec.entry_class = CLASS_DOT;
          else rec.entry_class = CLASS_NORMAL;
          rec.is_directory = (mode_val & 32'o170000) == 32'o040000;
          if (trl) begin
            rec.kind  = KIND_TRAILER;
            arc_phase = PH_DONE;
            return 1'b1;
          end
          // Name padding, then data.
          pad = (32'd0 - nxt) & 32'd3;
          if (pad != 0) begin
            arc_phase = PH_NAMEPAD;
            run_left  = pad;
          end else begin
            enter_data(nxt);
          end
        end
        return 1'b1;
      end
      PH_NAMEPAD: begin
        run_left = run_left - 32'd1;
        if (run_left == 0) enter_data(nxt);
        return 1'b0;
      end
      PH_DATA: begin
        show = data_on && !(dot_ok && name_pos >= 2);
        run_left = run_left - 32'd1;
        if (show) begin
          rec.kind         = KIND_DATA;
          rec.byte_value   = b;
          rec.last_of_data = run_left == 0;
        end
        if (run_left == 0) enter_data_pad(nxt);
        return show;
      end
      PH_DATAPAD: begin
        run_left = run_left - 32'd1;
        if (run_left == 0) enter_header();
        return 1'b0;
      end
      default: begin
        arc_phase = PH_DONE;
        return 1'b0;
      end
    endcase
  endfunction

  // Archive generation.
  task automatic put_byte(input logic [7:0] b);
    archive_bytes.push_back(b);
    stream_len++;
  endtask

  // Eight hex characters of mixed case. Value fields may carry a non-hex last
  // digit that still decodes to the same value; other fields may be junk.
  task automatic put_field(input logic [31:0] v, input bit junk_ok);
    logic [31:0] w;
    logic [3:0]  nib;
    bit          junk;
    bit          bad_last;
    int          i;
    junk     = junk_ok && ($urandom_range(0, 3) == 0);
    bad_last = !junk && v[3:0] == 4'hF && $urandom_range(0, 99) < bad_digit_pct;
    w        = bad_last ? v + 32'd1 : v;
    for (i = 0; i < 8; i++) begin
      nib = w[31 - 4*i -: 4];
      if (junk) put_byte(8'($urandom_range(0, 255)));
      else if (bad_last && i == 7) put_byte(non_hex[$urandom_range(0, 9)]);
      else if (nib < 4'd10) put_byte(8'h30 + nib);
      else if ($urandom_range(0, 1) == 1) put_byte(8'h61 + nib - 8'd10);
      else put_byte(8'h41 + nib - 8'd10);
    end
  endtask

  task automatic add_header(input int bad_pos, input logic [31:0] mode,
                            input logic [31:0] fsize, input logic [31:0] nsize);
    logic [7:0] c;
    int         i;
    for (i = 0; i < 6; i++) begin
      c = MagicText[47 - 8*i -: 8];
      if (i == bad_pos) c = c ^ 8'($urandom_range(1, 255));
      put_byte(c);
    end
    put_field($urandom, 1'b1);
    put_field(mode, 1'b0);
    repeat (4) put_field($urandom, 1'b1);
    put_field(fsize, 1'b0);
    repeat (4) put_field($urandom, 1'b1);
    put_field(nsize, 1'b0);
    put_field($urandom, 1'b1);
  endtask

  task automatic pad_to_word();
    while (stream_len % 4 != 0) put_byte(8'($urandom_range(0, 255)));
  endtask

  // One whole entry with the name held in name_buf.
  task automatic add_entry(input logic [31:0] mode, input logic [31:0] fsize);
    add_header(-1, mode, fsize, name_buf.size());
    foreach (name_buf[i]) put_byte(name_buf[i]);
    pad_to_word();
    repeat (fsize) put_byte(8'($urandom_range(0, 255)));
    pad_to_word();
  endtask

  task automatic set_name(input string s, input bit with_nul);
    int i;
    name_buf.delete();
    for (i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
    if (with_nul) name_buf.push_back(8'h00);
  endtask

  function automatic logic [31:0] random_mode();
    case ($urandom_range(0, 3))
      0: return 32'o040000 | $urandom_range(0, 12'o7777);
      1: return 32'o100000 | $urandom_range(0, 12'o7777);
      2: return $urandom;
      default: return 32'o040755;
    endcase
  endfunction

  // Mostly random names, with the names that look like a dot or a trailer.
  task automatic add_random_entry();
    int pick;
    int len;
    pick = $urandom_range(0, 19);
    case (pick)
      0: set_name(".", 1'b1);
      1: set_name("TRAILER!!", 1'b1);
      2: set_name("TRAILER!!!x", 1'b1);
      3: set_name(".", 1'b0);
      4: set_name("TRAILER!!!", 1'b0);
      5: set_name(".q", 1'b1);
      default: begin
        name_buf.delete();
        len = $urandom_range(1, 14);
        repeat (len) name_buf.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) != 0) name_buf.push_back(8'h00);
      end
    endcase
    if ($urandom_range(0, 99) < 3) add_entry(random_mode(), $urandom_range(100, 300));
    else add_entry(random_mode(), $urandom_range(0, 24));
  endtask

  task automatic fill_until(input int unsigned target);
    while (stream_len < target) add_random_entry();
  endtask

  // Configuration write request; the model takes the value on the handshake.
  task automatic write_register(input logic [CfgIndexW-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_ARCHIVE_LENGTH) length_limit = val;
    else if (idx == CFG_EMIT_DATA) data_on = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // All bytes sent and all records out, then a wait for the parser to settle.
  task automatic wait_idle();
    while (archive_bytes.size() != 0 || in_push || parsed_records.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Byte request driver, with random gaps and an occasional wait for all records.
  always @(negedge clk) begin : drive_archive
    logic       push_next;
    logic [7:0] byte_next;
    push_next = 1'b0;
    byte_next = in_archive_byte;
    if (rst_n) begin
      if (in_push && !byte_taken) begin
        push_next = 1'b1;
      end else if (hold_for_results) begin
        if (parsed_records.size() == 0) hold_for_results = 1'b0;
      end else if (archive_bytes.size() != 0) begin
        if ((bytes_taken == 500 && !forced_pause_done) || $urandom_range(0, 299) == 0) begin
          hold_for_results  = 1'b1;
          forced_pause_done = 1'b1;
        end else if ($urandom_range(0, 99) >= tx_idle_pct) begin
          push_next = 1'b1;
          byte_next = archive_bytes.pop_front();
        end
      end
    end
    byte_taken = 1'b0;
    in_push         <= push_next;
    in_archive_byte <= byte_next;
  end

  // Record consumer with random stalls.
  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Accepted byte requests feed the model; popped records are checked in order.
  always @(posedge clk) begin : check_records
    res_t want;
    res_t rec;
    if (rst_n && in_push && !in_full) begin
      byte_taken = 1'b1;
      bytes_taken++;
      if (parse_archive_byte(in_archive_byte, rec)) parsed_records.push_back(rec);
    end
    if (rst_n && out_pop && !out_empty) begin
      records_seen++;
      if (parsed_records.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("record %0d arrived with none expected: kind %0d byte %02h",
                   records_seen, out_kind, out_byte_value);
      end else begin
        want = parsed_records.pop_front();
        if (out_kind !== want.kind || out_byte_value !== want.byte_value ||
            out_last_of_name !== want.last_of_name ||
            out_entry_class !== want.entry_class ||
            out_is_directory !== want.is_directory ||
            out_file_size !== want.file_size ||
            out_last_of_data !== want.last_of_data) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"record %0d expected: kind %0d byte %02h nlast %b class %0d",
                      " dir %b size %08h dlast %b"},
                     records_seen, want.kind, want.byte_value, want.last_of_name,
                     want.entry_class, want.is_directory, want.file_size, want.last_of_data);
            $display({"record %0d actual:   kind %0d byte %02h nlast %b class %0d",
                      " dir %b size %08h dlast %b"},
                     records_seen, out_kind, out_byte_value, out_last_of_name,
                     out_entry_class, out_is_directory, out_file_size, out_last_of_data);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : run_archive
    logic [31:0] limit_val;
    int          end_kind;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // First pass: data on, unlimited length, slow sender against a slower receiver.
    tx_idle_pct = 19;
    rx_idle_pct = 52;
    write_register(CFG_ARCHIVE_LENGTH, 32'hFFFF_FFFF);
    write_register(CFG_EMIT_DATA, 32'd1);

    // Directed entries: plain file, directory, dot entries, near-trailer names,
    // names without a NUL, and fields with a non-hex last digit.
    bad_digit_pct = 100;
    set_name("a", 1'b1);
    add_entry(32'o100644, 32'd0);
    set_name("dir", 1'b1);
    add_entry(32'o040755, 32'd0);
    set_name("hello.txt", 1'b1);
    add_entry(32'o100644, 32'd5);
    set_name(".", 1'b1);
    add_entry(32'o040755, 32'd6);
    set_name(".x", 1'b1);
    add_entry(32'o100600, 32'd1);
    set_name(".", 1'b0);
    add_entry(32'o100644, 32'd2);
    set_name("", 1'b1);
    add_entry(32'h0000_41FF, 32'd3);
    set_name("TRAILER!!", 1'b1);
    add_entry(32'hFFFF_FFFF, 32'd31);
    set_name("TRAILER!!!", 1'b0);
    add_entry(32'o040000, 32'd4);
    set_name("TRAILER!!!xyzw", 1'b1);
    add_entry(32'o100000, 32'd8);
    name_buf.delete();
    name_buf.push_back(8'hFF);
    name_buf.push_back(8'h00);
    name_buf.push_back(8'h80);
    name_buf.push_back(8'h7F);
    name_buf.push_back(8'h00);
    add_entry(32'd0, 32'd7);

    bad_digit_pct = 30;
    fill_until(800);
    wait_idle();

    // Second pass: names only, a large but unreached length limit.
    tx_idle_pct = 52;
    rx_idle_pct = 19;
    write_register(CFG_EMIT_DATA, 32'd0);
    write_register(CFG_ARCHIVE_LENGTH, stream_len + 100000 + $urandom_range(0, 1000));
    fill_until(1500);
    wait_idle();

    // Third pass: full rate on both sides, then one way of ending the archive.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_register(CFG_EMIT_DATA, 32'd1);
    write_register(CFG_ARCHIVE_LENGTH, 32'hFFFF_FFFF);
    fill_until(2100);
    end_kind = $urandom_range(END_TRAILER, END_LENGTH);
    case (end_kind)
      END_TRAILER: begin
        set_name("TRAILER!!!", 1'b1);
        if ($urandom_range(0, 1) == 1) name_buf.push_back(8'($urandom_range(0, 255)));
        add_entry(random_mode(), $urandom_range(0, 20));
      end
      END_BAD_MAGIC: add_header($urandom_range(0, 5), random_mode(), 32'd4, 32'd6);
      END_NO_NAME:   add_header(-1, random_mode(), $urandom_range(0, 20), 32'd0);
      default: begin
        wait_idle();
        case ($urandom_range(0, 2))
          0: limit_val = 32'd0;
          1: limit_val = stream_len;
          default: limit_val = stream_len + $urandom_range(1, 100);
        endcase
        write_register(CFG_ARCHIVE_LENGTH, limit_val);
        if (limit_val > stream_len) add_random_entry();
      end
    endcase
    // Bytes after the end must be taken and give nothing.
    repeat (40) put_byte(8'($urandom_range(0, 255)));
    wait_idle();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && parsed_records.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
sv/cnp_pkg.sv
sv/cnp_front.sv
sv/cnp_queue.sv
sv/cpio_newc_archive_stream_parser.sv
bench/cpio_newc_archive_stream_parser_tb.sv
